// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- src/dct8_pkg.sv -----
// Shared types, widths and cosine weights of the 8x8 forward DCT.
`timescale 1ns / 1ps
`default_nettype none
package dct8_pkg;
  localparam int COS_FRAC_BITS = 14;
  localparam int WGT_W = COS_FRAC_BITS + 2;
  localparam int T_W = COS_FRAC_BITS + 11;
  localparam int PROD_W = T_W + WGT_W;
  localparam int ACC_W = 2 * COS_FRAC_BITS + 14;
  localparam int CEIL_SH = 2 * COS_FRAC_BITS + 2;
  localparam int COS_SH = 30 - COS_FRAC_BITS;
  localparam int COEF_W = 12;
  localparam int DC_W = 14;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [T_W-1:0] t_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DC_W-1:0] dc_t;

  typedef struct packed {
    logic       mac_en;
    logic       clr;
    logic       col;
    logic       t_wr;
    logic [2:0] idx;
  } lane_ctl_t;

  // cos(k*pi/16) in Q30 for k = 0..8.
  localparam longint COS_Q30 [9] = '{
    64'd1073741824, 64'd1053110176, 64'd992008094, 64'd892783698, 64'd759250125,
    64'd596538995, 64'd410903207, 64'd209476638, 64'd0
  };

  function automatic wgt_t weight(input logic [2:0] u, input logic [2:0] x);
    logic [6:0] prod;
    logic [4:0] k;
    logic [3:0] idx;
    logic       neg;
    longint     v;
    prod = {3'b000, x, 1'b1} * {4'b0000, u};
    k = prod[4:0];
    neg = 1'b0;
    if (u == 3'd0) begin
      idx = 4'd4;
    end else if (k <= 5'd8) begin
      idx = k[3:0];
    end else if (k <= 5'd16) begin
      idx = 4'(5'd16 - k);
      neg = 1'b1;
    end else if (k <= 5'd24) begin
      idx = 4'(k - 5'd16);
      neg = 1'b1;
    end else begin
      idx = 4'(6'd32 - {1'b0, k});
    end
    v = (COS_Q30[idx] + (64'sd1 <<< (COS_SH - 1))) >>> COS_SH;
    if (neg) begin
      v = -v;
    end
    return WGT_W'(v);
  endfunction
endpackage
`default_nettype wire

// ----- src/dct8_lane.sv -----
// One multiply-accumulate lane with its column of row-pass results.
`timescale 1ns / 1ps
`default_nettype none
module dct8_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dct8_pkg::lane_ctl_t ctl,
  input  wire logic signed [7:0]   sample,
  input  wire dct8_pkg::wgt_t      wgt,
  output dct8_pkg::acc_t           acc
);
  dct8_pkg::t_t    t_mem [8];
  dct8_pkg::t_t    opnd;
  dct8_pkg::prod_t prod;
  logic            pv;
  logic            pfirst;

  // Row pass multiplies samples; column pass multiplies stored row results.
  assign opnd = ctl.col ? t_mem[ctl.idx] : dct8_pkg::t_t'(sample);

  always_ff @(posedge clk) begin
    if (ctl.mac_en) begin
      prod <= opnd * wgt;
    end
    pfirst <= ctl.clr;
    if (pv) begin
      acc <= pfirst ? dct8_pkg::acc_t'(prod) : acc + dct8_pkg::acc_t'(prod);
    end
    if (ctl.t_wr) begin
      t_mem[ctl.idx] <= acc[dct8_pkg::T_W-1:0];
    end
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= ctl.mac_en;
    end
  end
endmodule
`default_nettype wire

// ----- src/dct8_merge.sv -----
// Rounds, saturates and registers one row of eight coefficients.
`timescale 1ns / 1ps
`default_nettype none
module dct8_merge (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire logic [2:0]     freq,
  input  wire dct8_pkg::acc_t accs [8],
  input  wire dct8_pkg::dc_t  dc_sum,
  input  wire logic           out_stall,
  output logic                out_valid,
  output dct8_pkg::coef_t     coefs [8],
  output logic [2:0]          freq_row,
  output logic                last
);
  localparam dct8_pkg::acc_t CEIL_ADD = dct8_pkg::acc_t'((64'd1 << dct8_pkg::CEIL_SH) - 64'd1);
  localparam dct8_pkg::acc_t C_MAX = dct8_pkg::acc_t'(2047);
  localparam dct8_pkg::acc_t C_MIN = -dct8_pkg::acc_t'(2048);

  dct8_pkg::coef_t coefs_next [8];
  dct8_pkg::acc_t  q [8];
  dct8_pkg::dc_t   dc_q;

  // A right shift after adding 2^s - 1 is a ceiling for either sign.
  assign dc_q = (dc_sum + dct8_pkg::dc_t'(7)) >>> 3;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      q[j] = (accs[j] + CEIL_ADD) >>> dct8_pkg::CEIL_SH;
      if (j == 0 && freq == 3'd0) begin
        q[j] = dct8_pkg::acc_t'(dc_q);
      end
      if (q[j] > C_MAX) begin
        coefs_next[j] = dct8_pkg::coef_t'(C_MAX);
      end else if (q[j] < C_MIN) begin
        coefs_next[j] = dct8_pkg::coef_t'(C_MIN);
      end else begin
        coefs_next[j] = q[j][dct8_pkg::COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      coefs <= coefs_next;
      freq_row <= freq;
      last <= (freq == 3'd7);
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- src/dct_8x8_forward_unit.sv -----
// Top level of the 8x8 forward DCT: row intake, sequencer, eight lanes and output stage.
// Each input word is one row of eight samples; a row is taken while the unit is idle and
// then runs through the eight multiply-accumulate lanes (eight products per lane, plus
// product register and accumulator); no new row is taken until that one is written back.
// After the eighth row the same lanes compute the column pass: each of the eight
// coefficient rows is held in an output register until taken, during which the next row is
// already being computed and waits in the lanes while that register is full. No new block
// row is taken until all eight coefficient rows have been computed. The first coefficient
// row of a block carries the DC term, the last carries last set.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dct_8x8_forward_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  pixel_0,
  input  wire logic [7:0]  pixel_1,
  input  wire logic [7:0]  pixel_2,
  input  wire logic [7:0]  pixel_3,
  input  wire logic [7:0]  pixel_4,
  input  wire logic [7:0]  pixel_5,
  input  wire logic [7:0]  pixel_6,
  input  wire logic [7:0]  pixel_7,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [11:0] coef_0,
  output logic signed [11:0] coef_1,
  output logic signed [11:0] coef_2,
  output logic signed [11:0] coef_3,
  output logic signed [11:0] coef_4,
  output logic signed [11:0] coef_5,
  output logic signed [11:0] coef_6,
  output logic signed [11:0] coef_7,
  output logic [2:0]       freq_row,
  output logic             last
);
  typedef enum logic [1:0] {S_IDLE, S_ROW, S_COL} state_t;

  state_t              state;
  logic [3:0]          cnt;
  logic [2:0]          row_count;
  logic [2:0]          freq;
  logic signed [7:0]   row_buf [8];
  logic signed [7:0]   px [8];
  logic signed [10:0]  row_sum;
  dct8_pkg::dc_t       dc_sum;
  dct8_pkg::lane_ctl_t ctl;
  dct8_pkg::acc_t      accs [8];
  dct8_pkg::coef_t     coefs [8];
  logic                in_acc;
  logic                out_acc;
  logic                load;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);

  // Flipping the top bit subtracts 128 and leaves a signed byte.
  assign px[0] = signed'(pixel_0 ^ 8'h80);
  assign px[1] = signed'(pixel_1 ^ 8'h80);
  assign px[2] = signed'(pixel_2 ^ 8'h80);
  assign px[3] = signed'(pixel_3 ^ 8'h80);
  assign px[4] = signed'(pixel_4 ^ 8'h80);
  assign px[5] = signed'(pixel_5 ^ 8'h80);
  assign px[6] = signed'(pixel_6 ^ 8'h80);
  assign px[7] = signed'(pixel_7 ^ 8'h80);

  always_comb begin
    row_sum = '0;
    for (int y = 0; y < 8; y++) begin
      row_sum = row_sum + 11'(px[y]);
    end
  end

  assign ctl.mac_en = (state == S_ROW || state == S_COL) && !cnt[3];
  assign ctl.clr = (cnt == 4'd0);
  assign ctl.col = (state == S_COL);
  assign ctl.t_wr = (state == S_ROW) && (cnt == 4'd9);
  assign ctl.idx = ctl.t_wr ? row_count : cnt[2:0];

  // The result row moves to the output stage once that stage is free.
  assign load = (state == S_COL) && (cnt == 4'd9) && (!out_valid || out_acc);

  for (genvar j = 0; j < 8; j++) begin : g_lane
    dct8_pkg::wgt_t wgt;
    assign wgt = ctl.col ? dct8_pkg::weight(freq, cnt[2:0])
                         : dct8_pkg::weight(3'(j), cnt[2:0]);
    dct8_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (row_buf[cnt[2:0]]),
      .wgt    (wgt),
      .acc    (accs[j])
    );
  end

  dct8_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .freq      (freq),
    .accs      (accs),
    .dc_sum    (dc_sum),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .coefs     (coefs),
    .freq_row  (freq_row),
    .last      (last)
  );

  assign coef_0 = coefs[0];
  assign coef_1 = coefs[1];
  assign coef_2 = coefs[2];
  assign coef_3 = coefs[3];
  assign coef_4 = coefs[4];
  assign coef_5 = coefs[5];
  assign coef_6 = coefs[6];
  assign coef_7 = coefs[7];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_buf <= px;
      dc_sum <= (row_count == 3'd0) ? dct8_pkg::dc_t'(row_sum)
                                    : dc_sum + dct8_pkg::dc_t'(row_sum);
    end
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      row_count <= '0;
      freq <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cnt <= '0;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (cnt == 4'd9) begin
            cnt <= '0;
            row_count <= row_count + 3'd1;
            if (row_count == 3'd7) begin
              freq <= '0;
              state <= S_COL;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_COL: begin
          if (cnt != 4'd9) begin
            cnt <= cnt + 4'd1;
          end else if (load) begin
            cnt <= '0;
            freq <= freq + 3'd1;
            if (freq == 3'd7) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_in_busy, clk, rst, in_acc, in_stall)
  `ASSERT_IMPLY(a_col_rows, clk, rst, state == S_COL, row_count == 3'd0)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_IMPLY(a_wr_idle, clk, rst, ctl.t_wr, !ctl.mac_en)
endmodule
`default_nettype wire
